// ===== rtl/core/fmsr_pkg.sv =====
// ----------------------------------------------------------------------------
// fmsr_pkg
// Shared types and constants of the four-motor speed ramp unit.
// ----------------------------------------------------------------------------
package fmsr_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int MOTOR_W     = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    localparam int SPEED_W     = 9;
    localparam int DIFF_W      = SPEED_W + 1;
    localparam int REQ_W       = 16;
    localparam int MAG_W       = 7;
    localparam int DUTY_W      = 8;
    localparam int IDX_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic signed [REQ_W-1:0] SPEED_LIMIT = 16'sd100;

    // x * 255 / 100 == (x * SCALE_MUL) >> SCALE_SHIFT for 0 <= x <= 100
    localparam int SCALE_SHIFT = 19;
    localparam int SCALE_MUL_W = 21;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 21'd1336965;
    localparam int PROD_W      = MAG_W + SCALE_MUL_W;

    localparam logic [DUTY_W-1:0] RAMP_STEP_RST   = 8'd50;
    localparam logic              RAMP_ENABLE_RST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_ENABLE = 1'd1;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SET  = 4'b0010,
        ST_RAMP = 4'b0100,
        ST_WAIT = 4'b1000
    } state_t;

endpackage

// ===== rtl/core/four_motor_speed_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// four_motor_speed_ramp_unit
// Slew-rate limiter for four H-bridge motor drives. A set word stores a
// clamped, scaled target speed for one motor; a tick word walks the motors
// and moves each current speed toward its target by at most ramp_step,
// emitting reverse and duty for every motor that changed.
// ----------------------------------------------------------------------------
// Timing: an input word is taken only while the unit is idle. A set word
// passes through the SET state; when ramping is off it also emits a result
// and waits in WAIT until m_ready takes it. A tick word runs a sequencer over
// the motors, one motor per cycle while no update waits on m_ready, through a
// single add/compare unit, and each emitted update holds the sequencer in
// WAIT until m_ready.
module four_motor_speed_ramp_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fmsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fmsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [fmsr_pkg::IDX_W-1:0]          s_motor_index,
    input  logic signed [fmsr_pkg::REQ_W-1:0]   s_speed_request,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fmsr_pkg::IDX_W-1:0]          m_out_motor,
    output logic                                m_reverse,
    output logic [fmsr_pkg::DUTY_W-1:0]         m_duty,
    output logic                                m_last
);

    fmsr_pkg::state_t state_reg, state_next;

    logic [fmsr_pkg::DUTY_W-1:0]               ramp_step_reg;
    logic                                      ramp_enable_reg;

    logic [fmsr_pkg::IDX_W-1:0]                idx_reg;
    logic signed [fmsr_pkg::REQ_W-1:0]         req_reg;

    logic signed [fmsr_pkg::SPEED_W-1:0]       target_reg  [fmsr_pkg::MOTOR_COUNT];
    logic signed [fmsr_pkg::SPEED_W-1:0]       current_reg [fmsr_pkg::MOTOR_COUNT];

    logic [fmsr_pkg::MOTOR_COUNT-1:0]          mask_reg;
    logic [fmsr_pkg::MOTOR_COUNT-1:0]          mask_now;
    logic [fmsr_pkg::MOTOR_COUNT-1:0]          mask_rest;
    logic [fmsr_pkg::MOTOR_W-1:0]              motor_reg;
    logic                                      more;

    logic                                      m_valid_reg;
    logic [fmsr_pkg::IDX_W-1:0]                m_out_motor_reg;
    logic                                      m_reverse_reg;
    logic [fmsr_pkg::DUTY_W-1:0]               m_duty_reg;
    logic                                      m_last_reg;

    logic                                      s_fire;
    logic                                      idx_ok;

    // set path: clamp, scale by 255/100
    logic                                      req_neg;
    logic [fmsr_pkg::MAG_W-1:0]                req_mag;
    logic [fmsr_pkg::PROD_W-1:0]               scale_prod;
    logic [fmsr_pkg::SPEED_W-1:0]              scaled_mag;
    logic signed [fmsr_pkg::SPEED_W-1:0]       scaled;

    // ramp path: shared add/compare unit
    logic signed [fmsr_pkg::SPEED_W-1:0]       cur_sel;
    logic signed [fmsr_pkg::SPEED_W-1:0]       tgt_sel;
    logic signed [fmsr_pkg::DIFF_W-1:0]        diff;
    logic signed [fmsr_pkg::DIFF_W-1:0]        step_s;
    logic signed [fmsr_pkg::DIFF_W-1:0]        ramp_sum;
    logic signed [fmsr_pkg::SPEED_W-1:0]       ramp_nv;

    logic signed [fmsr_pkg::SPEED_W-1:0]       drive_val;
    logic [fmsr_pkg::SPEED_W-1:0]              drive_mag;

    assign s_ready     = (state_reg == fmsr_pkg::ST_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_out_motor = m_out_motor_reg;
    assign m_reverse   = m_reverse_reg;
    assign m_duty      = m_duty_reg;
    assign m_last      = m_last_reg;

    always_comb begin
        for (int i = 0; i < fmsr_pkg::MOTOR_COUNT; i++) begin
            mask_now[i] = (current_reg[i] != target_reg[i]);
        end
    end

    assign mask_rest = mask_reg >> motor_reg;
    assign more      = |(mask_rest >> 1);

    assign idx_ok = (32'(idx_reg) < fmsr_pkg::MOTOR_COUNT);

    always_comb begin
        req_neg = req_reg < 0;
        if (req_reg > fmsr_pkg::SPEED_LIMIT || req_reg < -fmsr_pkg::SPEED_LIMIT) begin
            req_mag = fmsr_pkg::MAG_W'(fmsr_pkg::SPEED_LIMIT);
        end else if (req_neg) begin
            req_mag = fmsr_pkg::MAG_W'(-req_reg);
        end else begin
            req_mag = fmsr_pkg::MAG_W'(req_reg);
        end
        scale_prod = fmsr_pkg::PROD_W'(req_mag) * fmsr_pkg::PROD_W'(fmsr_pkg::SCALE_MUL);
        scaled_mag = scale_prod[fmsr_pkg::SCALE_SHIFT +: fmsr_pkg::SPEED_W];
        scaled     = req_neg ? -$signed(scaled_mag) : $signed(scaled_mag);
    end

    always_comb begin
        cur_sel = current_reg[motor_reg];
        tgt_sel = target_reg[motor_reg];
        diff    = fmsr_pkg::DIFF_W'(tgt_sel) - fmsr_pkg::DIFF_W'(cur_sel);
        step_s  = $signed(fmsr_pkg::DIFF_W'(ramp_step_reg));
        if (diff > step_s) begin
            ramp_sum = fmsr_pkg::DIFF_W'(cur_sel) + step_s;
        end else if (diff < -step_s) begin
            ramp_sum = fmsr_pkg::DIFF_W'(cur_sel) - step_s;
        end else begin
            ramp_sum = fmsr_pkg::DIFF_W'(tgt_sel);
        end
        ramp_nv = fmsr_pkg::SPEED_W'(ramp_sum);
    end

    always_comb begin
        drive_val = (state_reg == fmsr_pkg::ST_SET) ? scaled : ramp_nv;
        drive_mag = drive_val < 0 ? fmsr_pkg::SPEED_W'(-drive_val)
                                  : fmsr_pkg::SPEED_W'(drive_val);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fmsr_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_cmd == fmsr_pkg::CMD_TICK) ? fmsr_pkg::ST_RAMP
                                                               : fmsr_pkg::ST_SET;
                end
            end
            fmsr_pkg::ST_SET: begin
                state_next = (idx_ok && !ramp_enable_reg) ? fmsr_pkg::ST_WAIT
                                                          : fmsr_pkg::ST_IDLE;
            end
            fmsr_pkg::ST_RAMP: begin
                if (mask_rest[0]) begin
                    state_next = fmsr_pkg::ST_WAIT;
                end else if (!more) begin
                    state_next = fmsr_pkg::ST_IDLE;
                end
            end
            fmsr_pkg::ST_WAIT: begin
                if (m_ready) begin
                    state_next = m_last_reg ? fmsr_pkg::ST_IDLE : fmsr_pkg::ST_RAMP;
                end
            end
            default: state_next = fmsr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fmsr_pkg::ST_IDLE;
            ramp_step_reg   <= fmsr_pkg::RAMP_STEP_RST;
            ramp_enable_reg <= fmsr_pkg::RAMP_ENABLE_RST;
            m_valid_reg     <= 1'b0;
            mask_reg        <= '0;
            motor_reg       <= '0;
            for (int i = 0; i < fmsr_pkg::MOTOR_COUNT; i++) begin
                target_reg[i]  <= '0;
                current_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    fmsr_pkg::REG_RAMP_STEP:   ramp_step_reg   <= cfg_wdata;
                    fmsr_pkg::REG_RAMP_ENABLE: ramp_enable_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                fmsr_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        idx_reg   <= s_motor_index;
                        req_reg   <= s_speed_request;
                        mask_reg  <= mask_now;
                        motor_reg <= '0;
                    end
                end
                fmsr_pkg::ST_SET: begin
                    if (idx_ok) begin
                        target_reg[fmsr_pkg::MOTOR_W'(idx_reg)] <= scaled;
                        if (!ramp_enable_reg) begin
                            current_reg[fmsr_pkg::MOTOR_W'(idx_reg)] <= scaled;
                            m_valid_reg     <= 1'b1;
                            m_out_motor_reg <= idx_reg;
                            m_reverse_reg   <= scaled < 0;
                            m_duty_reg      <= fmsr_pkg::DUTY_W'(drive_mag);
                            m_last_reg      <= 1'b1;
                        end
                    end
                end
                fmsr_pkg::ST_RAMP: begin
                    if (mask_rest[0]) begin
                        current_reg[motor_reg] <= ramp_nv;
                        m_valid_reg     <= 1'b1;
                        m_out_motor_reg <= fmsr_pkg::IDX_W'(motor_reg);
                        m_reverse_reg   <= ramp_nv < 0;
                        m_duty_reg      <= fmsr_pkg::DUTY_W'(drive_mag);
                        m_last_reg      <= !more;
                    end else begin
                        motor_reg <= motor_reg + 1'b1;
                    end
                end
                fmsr_pkg::ST_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (!m_last_reg) begin
                            motor_reg <= motor_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/fmsr_checker.sv =====
// ----------------------------------------------------------------------------
// fmsr_checker
// Port-level checks for the four-motor speed ramp unit, bound to its top.
// ----------------------------------------------------------------------------
module fmsr_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fmsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fmsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [fmsr_pkg::IDX_W-1:0]          s_motor_index,
    input  logic signed [fmsr_pkg::REQ_W-1:0]   s_speed_request,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [fmsr_pkg::IDX_W-1:0]          m_out_motor,
    input  logic                                m_reverse,
    input  logic [fmsr_pkg::DUTY_W-1:0]         m_duty,
    input  logic                                m_last
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_motor) && $stable(m_reverse)
                                && $stable(m_duty) && $stable(m_last))
        else $error("stalled result word changed");

    // drop ready in the cycle after taking a word
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

    // no intake while a result word is pending
    a_no_take_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("ready while result pending");

    // a set word shows no result in the cycle after it is taken
    a_set_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == fmsr_pkg::CMD_SET |=> !m_valid)
        else $error("set result too early");

endmodule

bind four_motor_speed_ramp_unit fmsr_checker u_fmsr_checker (.*);
